// ----- src/assert_macros.svh -----
// Assertion macros for the file that carries concurrent checks, the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in pid heading hold");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in pid heading hold");

`endif

// ----- src/phh_pkg.sv -----
// Shared widths, codes and reset values of the heading hold regulator.
package phh_pkg;

    localparam int OPCODE_W    = 2;
    localparam int ANGLE_W     = 24;
    localparam int DIST_W      = 32;
    localparam int TURN_W      = 32;
    localparam int POWER_W     = 16;
    localparam int GAIN_W      = 24;
    localparam int PERIOD_W    = 16;
    localparam int ERR_W       = 32;
    localparam int INTEG_W     = 48;
    localparam int FRAC_W      = 16;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int DERIV_W     = DIFF_W + PERIOD_W;
    localparam int STEP_PROD_W = ERR_W + PERIOD_W;
    localparam int PTERM_W     = ERR_W + GAIN_W;
    localparam int ITERM_W     = INTEG_W + GAIN_W;
    localparam int DTERM_W     = DERIV_W + GAIN_W;
    localparam int SUM_W       = DTERM_W + 2;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    typedef logic [OPCODE_W-1:0]  t_opcode;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_opcode OP_START  = 2'd0;
    localparam t_opcode OP_SAMPLE = 2'd1;
    localparam t_opcode OP_STOP   = 2'd2;

    localparam t_reg_idx REG_USE_GYRO       = 3'd0;
    localparam t_reg_idx REG_GAIN_P         = 3'd1;
    localparam t_reg_idx REG_GAIN_I         = 3'd2;
    localparam t_reg_idx REG_GAIN_D         = 3'd3;
    localparam t_reg_idx REG_SAMPLE_PERIOD  = 3'd4;
    localparam t_reg_idx REG_INVERSE_PERIOD = 3'd5;
    localparam t_reg_idx REG_DRIVE_POWER    = 3'd6;

    localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD  = 16'd1311;
    localparam logic [PERIOD_W-1:0] RST_INVERSE_PERIOD = 16'd50;

endpackage

// ----- src/phh_if.sv -----
// Valid/ready channel interfaces for the input items and the result words.
interface phh_in_if;
    import phh_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OPCODE_W-1:0]       opcode;
    logic signed [ANGLE_W-1:0] gyro_angle;
    logic signed [DIST_W-1:0]  left_distance;
    logic signed [DIST_W-1:0]  right_distance;

    modport source (
        output valid, opcode, gyro_angle, left_distance, right_distance,
        input  ready
    );
    modport sink (
        input  valid, opcode, gyro_angle, left_distance, right_distance,
        output ready
    );
endinterface

interface phh_out_if;
    import phh_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [TURN_W-1:0]  turn_power;
    logic signed [POWER_W-1:0] forward_power;
    logic                      stop_flag;

    modport source (
        output valid, turn_power, forward_power, stop_flag,
        input  ready
    );
    modport sink (
        input  valid, turn_power, forward_power, stop_flag,
        output ready
    );
endinterface

// ----- src/phh_mul_serial.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module phh_mul_serial #(
    parameter int A_W      = 32,
    parameter int B_W      = 16,
    parameter bit B_SIGNED = 1'b0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [A_W-1:0]    i_a,
    input  logic [B_W-1:0]           i_b,
    output logic                     o_busy,
    output logic signed [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

    logic                   r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [A_W-1:0]  r_a;
    logic signed [A_W:0]    r_hi;
    logic [B_W-1:0]         r_lo;
    logic signed [A_W:0]    n_sum;
    logic [A_W:0]           a_ext;
    logic                   subtract;

    // The top bit of a signed multiplier carries negative weight.
    always_comb begin
        a_ext    = {r_a[A_W-1], r_a};
        subtract = B_SIGNED && (r_cnt == LAST);
        if (!r_lo[0]) begin
            n_sum = r_hi;
        end else if (subtract) begin
            n_sum = r_hi - a_ext;
        end else begin
            n_sum = r_hi + a_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == LAST)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_hi  <= '0;
            r_lo  <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_hi  <= {n_sum[A_W], n_sum[A_W:1]};
            r_lo  <= {n_sum[0], r_lo[B_W-1:1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_hi[A_W-1:0], r_lo};

endmodule

// ----- src/phh_gyro_err.sv -----
// Gyro heading error: serial reduction modulo 360 and serial division by 180.
module phh_gyro_err (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [phh_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_busy,
    output logic signed [phh_pkg::ERR_W-1:0]   o_error
);
    import phh_pkg::*;

    localparam int FRAC_DEG_W = 8;
    localparam int MAG_W      = ANGLE_W - FRAC_DEG_W;
    localparam int DEG_FULL_I = 360;
    localparam int DEG_HALF_I = 180;
    localparam int DIVISOR_I  = 45;
    localparam int QUO_SHIFT  = 14;
    localparam int REM_W      = $clog2(DEG_FULL_I);
    localparam int DVR_W      = $clog2(DIVISOR_I);
    localparam int DVD_W      = REM_W + QUO_SHIFT;
    localparam int CNT_W      = $clog2(DVD_W);

    localparam logic [REM_W:0]   DEG_FULL = (REM_W + 1)'(DEG_FULL_I);
    localparam logic [REM_W-1:0] DEG_HALF = REM_W'(DEG_HALF_I);
    localparam logic [DVR_W:0]   DIVISOR  = (DVR_W + 1)'(DIVISOR_I);
    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_MOD  = 2'd1;
    localparam logic [1:0] G_WRAP = 2'd2;
    localparam logic [1:0] G_DIV  = 2'd3;

    logic [1:0]              r_phase;
    logic [1:0]              n_phase;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic [REM_W-1:0]        r_rem;
    logic [DVR_W-1:0]        r_dr;
    logic [DVD_W-1:0]        r_dvd;
    logic [ANGLE_W-1:0]      angle_abs;
    logic [REM_W:0]          mod_try;
    logic [REM_W-1:0]        mod_next;
    logic                    wrap;
    logic [REM_W-1:0]        wrapped;
    logic [DVR_W:0]          div_try;
    logic                    div_ge;
    logic [DVR_W-1:0]        div_next;
    logic signed [ERR_W-1:0] q_ext;

    always_comb begin
        angle_abs = i_angle[ANGLE_W-1] ? ANGLE_W'(-i_angle) : ANGLE_W'(i_angle);
        mod_try   = {r_rem, r_mag[MAG_W-1]};
        mod_next  = (mod_try >= DEG_FULL) ? REM_W'(mod_try - DEG_FULL) : mod_try[REM_W-1:0];
        wrap      = !r_neg && (r_rem > DEG_HALF);
        wrapped   = wrap ? REM_W'(DEG_FULL - {1'b0, r_rem}) : r_rem;
        div_try   = {r_dr, r_dvd[DVD_W-1]};
        div_ge    = (div_try >= DIVISOR);
        div_next  = div_ge ? DVR_W'(div_try - DIVISOR) : div_try[DVR_W-1:0];
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            G_IDLE: begin
                if (i_start) begin
                    n_phase = G_MOD;
                end
            end
            G_MOD: begin
                if (r_cnt == MOD_LAST) begin
                    n_phase = G_WRAP;
                end
            end
            G_WRAP: begin
                n_phase = G_DIV;
            end
            G_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_phase = G_IDLE;
                end
            end
            default: begin
                n_phase = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= G_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_angle[ANGLE_W-1];
            r_mag <= angle_abs[ANGLE_W-1:FRAC_DEG_W];
            r_rem <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_phase)
                G_MOD: begin
                    r_rem <= mod_next;
                    r_mag <= r_mag << 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                G_WRAP: begin
                    r_dvd <= {wrapped, {QUO_SHIFT{1'b0}}};
                    r_dr  <= '0;
                    r_cnt <= '0;
                    if (wrap) begin
                        r_neg <= 1'b1;
                    end
                end
                G_DIV: begin
                    r_dr  <= div_next;
                    r_dvd <= {r_dvd[DVD_W-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // The quotient ends up in the dividend register; a negative angle gives a positive error.
    assign q_ext   = ERR_W'(r_dvd);
    assign o_error = r_neg ? q_ext : -q_ext;
    assign o_busy  = (r_phase != G_IDLE);

endmodule

// ----- src/pid_heading_hold_top.sv -----
// Top level of the PID heading hold regulator for a drive base.
// Input words arrive on i_in and results leave on o_out; both are valid/ready
// channels and a word moves at a clock edge where valid and ready are high.
// Gains, periods, drive power and the error source are set over the APB port;
// it is to be written only while the block is idle, which the block itself
// does not enforce. A start word clears the integral and the previous error as
// it is taken and gives no result. A stop word gives a result with only the
// stop flag set, which the DONE state loads into the output register once that
// register is free. A sample word's result passes the error step (encoder
// difference, or the gyro unit's serial modulo and division), the integral step
// and derivative products, the three gain products and the sum steps, then is
// loaded; all products run on bit-serial multipliers of one bit a cycle.
// One word is processed at a time and the input reopens in the cycle after the
// result is loaded.
// The result sits in an output register, so a new word is taken while the
// previous result still waits; a stalled receiver holds the block only
// when the next result is ready to be loaded.
// Reset restores the register defaults, clears the integral and the
// previous error and empties the output register.
`include "assert_macros.svh"

module pid_heading_hold_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    phh_in_if.sink                         i_in,
    phh_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [phh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [phh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [phh_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import phh_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ENC     = 4'd1;
    localparam logic [3:0] ST_GYRO    = 4'd2;
    localparam logic [3:0] ST_LAUNCH1 = 4'd3;
    localparam logic [3:0] ST_MUL1    = 4'd4;
    localparam logic [3:0] ST_LAUNCH2 = 4'd5;
    localparam logic [3:0] ST_MUL2    = 4'd6;
    localparam logic [3:0] ST_SUM1    = 4'd7;
    localparam logic [3:0] ST_SUM2    = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    localparam logic signed [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [TURN_W-1:0]  TURN_MAX  = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0]  TURN_MIN  = {1'b1, {(TURN_W-1){1'b0}}};
    localparam logic signed [ERR_W-1:0]   GYRO_ERR_LIMIT = ERR_W'(131072);

    logic [3:0]                 r_state;
    logic [3:0]                 n_state;
    logic                       in_fire;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;

    logic                       r_use_gyro;
    logic signed [GAIN_W-1:0]   r_gain_p;
    logic signed [GAIN_W-1:0]   r_gain_i;
    logic signed [GAIN_W-1:0]   r_gain_d;
    logic [PERIOD_W-1:0]        r_sample_period;
    logic [PERIOD_W-1:0]        r_inverse_period;
    logic signed [POWER_W-1:0]  r_drive_power;

    logic                       r_is_stop;
    logic signed [DIST_W:0]     r_left_abs;
    logic signed [DIST_W:0]     r_right_abs;
    logic signed [DIST_W:0]     left_ext;
    logic signed [DIST_W:0]     right_ext;
    logic signed [DIST_W:0]     enc_diff;
    logic signed [ERR_W-1:0]    enc_err;

    logic signed [ERR_W-1:0]    r_err;
    logic signed [ERR_W-1:0]    r_prev;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [STEP_PROD_W-FRAC_W-1:0] step;
    logic signed [DIFF_W-1:0]   err_diff;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    total;
    logic signed [TURN_W-1:0]   r_turn;
    logic signed [TURN_W-1:0]   turn_sat;
    logic [SUM_W-FRAC_W-TURN_W:0] turn_top;

    logic                       gyro_start;
    logic                       gyro_busy;
    logic signed [ERR_W-1:0]    gyro_err;
    logic                       launch1;
    logic                       launch2;
    logic                       step_busy;
    logic                       deriv_busy;
    logic                       p_busy;
    logic                       i_busy;
    logic                       d_busy;
    logic                       mul1_done;
    logic                       mul2_done;
    logic signed [STEP_PROD_W-1:0] step_prod;
    logic signed [DERIV_W-1:0]  deriv;
    logic signed [PTERM_W-1:0]  p_term;
    logic signed [ITERM_W-1:0]  i_term;
    logic signed [DTERM_W-1:0]  d_term;

    logic                       out_load;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [TURN_W-1:0]   r_out_turn;
    logic signed [POWER_W-1:0]  r_out_fwd;
    logic                       r_out_stop;

    logic                       start_fire;
    logic                       gyro_done;
    logic                       gyro_in_range;
    logic                       lanes_level;
    logic                       stop_shown;
    logic                       stop_zero;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_gyro       <= 1'b1;
            r_gain_p         <= '0;
            r_gain_i         <= '0;
            r_gain_d         <= '0;
            r_sample_period  <= RST_SAMPLE_PERIOD;
            r_inverse_period <= RST_INVERSE_PERIOD;
            r_drive_power    <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_USE_GYRO:       r_use_gyro       <= pwdata[0];
                REG_GAIN_P:         r_gain_p         <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:         r_gain_i         <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:         r_gain_d         <= pwdata[GAIN_W-1:0];
                REG_SAMPLE_PERIOD:  r_sample_period  <= pwdata[PERIOD_W-1:0];
                REG_INVERSE_PERIOD: r_inverse_period <= pwdata[PERIOD_W-1:0];
                REG_DRIVE_POWER:    r_drive_power    <= pwdata[POWER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_USE_GYRO:       prdata = APB_DATA_W'(r_use_gyro);
            REG_GAIN_P:         prdata = APB_DATA_W'(r_gain_p);
            REG_GAIN_I:         prdata = APB_DATA_W'(r_gain_i);
            REG_GAIN_D:         prdata = APB_DATA_W'(r_gain_d);
            REG_SAMPLE_PERIOD:  prdata = APB_DATA_W'(r_sample_period);
            REG_INVERSE_PERIOD: prdata = APB_DATA_W'(r_inverse_period);
            REG_DRIVE_POWER:    prdata = APB_DATA_W'(r_drive_power);
            default:            prdata = '0;
        endcase
    end

    // Sequencer.
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign gyro_start = in_fire && (i_in.opcode == OP_SAMPLE) && r_use_gyro;
    assign launch1    = (r_state == ST_LAUNCH1);
    assign launch2    = (r_state == ST_LAUNCH2);
    assign mul1_done  = !step_busy && !deriv_busy;
    assign mul2_done  = !p_busy && !i_busy && !d_busy;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.opcode)
                        OP_SAMPLE: n_state = r_use_gyro ? ST_GYRO : ST_ENC;
                        OP_STOP:   n_state = ST_DONE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ENC:     n_state = ST_LAUNCH1;
            ST_GYRO: begin
                if (!gyro_busy) begin
                    n_state = ST_LAUNCH1;
                end
            end
            ST_LAUNCH1: n_state = ST_MUL1;
            ST_MUL1: begin
                if (mul1_done) begin
                    n_state = ST_LAUNCH2;
                end
            end
            ST_LAUNCH2: n_state = ST_MUL2;
            ST_MUL2: begin
                if (mul2_done) begin
                    n_state = ST_SUM1;
                end
            end
            ST_SUM1:    n_state = ST_SUM2;
            ST_SUM2:    n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Error, integral and sum arithmetic.
    always_comb begin
        left_ext  = (DIST_W + 1)'(i_in.left_distance);
        right_ext = (DIST_W + 1)'(i_in.right_distance);
        enc_diff  = r_right_abs - r_left_abs;
        if (enc_diff[DIST_W] != enc_diff[DIST_W-1]) begin
            enc_err = enc_diff[DIST_W] ? ERR_MIN : ERR_MAX;
        end else begin
            enc_err = enc_diff[ERR_W-1:0];
        end

        err_diff  = DIFF_W'(r_err) - DIFF_W'(r_prev);
        step      = step_prod[STEP_PROD_W-1:FRAC_W];
        integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(step);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end

        // Dropping the sixteen fraction bits floors the sum.
        total    = r_sum + SUM_W'(d_term);
        turn_top = total[SUM_W-1:FRAC_W+TURN_W-1];
        if ((&turn_top) || !(|turn_top)) begin
            turn_sat = total[FRAC_W+TURN_W-1:FRAC_W];
        end else begin
            turn_sat = total[SUM_W-1] ? TURN_MIN : TURN_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (in_fire && (i_in.opcode == OP_START)) begin
                r_integ <= '0;
                r_prev  <= '0;
            end else if ((r_state == ST_MUL1) && mul1_done) begin
                r_integ <= integ_next;
                r_prev  <= r_err;
            end
        end
    end

    assign n_out_valid = out_load || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_is_stop   <= (i_in.opcode == OP_STOP);
            r_left_abs  <= left_ext[DIST_W] ? -left_ext : left_ext;
            r_right_abs <= right_ext[DIST_W] ? -right_ext : right_ext;
        end
        if (r_state == ST_ENC) begin
            r_err <= enc_err;
        end else if ((r_state == ST_GYRO) && !gyro_busy) begin
            r_err <= gyro_err;
        end
        if (r_state == ST_SUM1) begin
            r_sum <= SUM_W'(p_term) + SUM_W'(i_term);
        end
        if (r_state == ST_SUM2) begin
            r_turn <= turn_sat;
        end
        if (out_load) begin
            r_out_turn <= r_is_stop ? '0 : r_turn;
            r_out_fwd  <= r_is_stop ? '0 : r_drive_power;
            r_out_stop <= r_is_stop;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.turn_power    = r_out_turn;
    assign o_out.forward_power = r_out_fwd;
    assign o_out.stop_flag     = r_out_stop;

    // Arithmetic units.
    phh_gyro_err u_gyro (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gyro_start),
        .i_angle (i_in.gyro_angle),
        .o_busy  (gyro_busy),
        .o_error (gyro_err)
    );

    phh_mul_serial #(.A_W(ERR_W), .B_W(PERIOD_W), .B_SIGNED(1'b0)) u_mul_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (launch1),
        .i_a     (r_err),
        .i_b     (r_sample_period),
        .o_busy  (step_busy),
        .o_prod  (step_prod)
    );

    phh_mul_serial #(.A_W(DIFF_W), .B_W(PERIOD_W), .B_SIGNED(1'b0)) u_mul_deriv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (launch1),
        .i_a     (err_diff),
        .i_b     (r_inverse_period),
        .o_busy  (deriv_busy),
        .o_prod  (deriv)
    );

    phh_mul_serial #(.A_W(ERR_W), .B_W(GAIN_W), .B_SIGNED(1'b1)) u_mul_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (launch2),
        .i_a     (r_err),
        .i_b     (r_gain_p),
        .o_busy  (p_busy),
        .o_prod  (p_term)
    );

    phh_mul_serial #(.A_W(INTEG_W), .B_W(GAIN_W), .B_SIGNED(1'b1)) u_mul_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (launch2),
        .i_a     (r_integ),
        .i_b     (r_gain_i),
        .o_busy  (i_busy),
        .o_prod  (i_term)
    );

    phh_mul_serial #(.A_W(DERIV_W), .B_W(GAIN_W), .B_SIGNED(1'b1)) u_mul_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (launch2),
        .i_a     (deriv),
        .i_b     (r_gain_d),
        .o_busy  (d_busy),
        .o_prod  (d_term)
    );

    // Checks.
    assign start_fire    = in_fire && (i_in.opcode == OP_START);
    assign gyro_done     = (r_state == ST_GYRO) && !gyro_busy;
    assign gyro_in_range = (gyro_err <= GYRO_ERR_LIMIT) && (gyro_err >= -GYRO_ERR_LIMIT);
    assign lanes_level   = (p_busy == i_busy) && (i_busy == d_busy);
    assign stop_shown    = o_out.valid && o_out.stop_flag;
    assign stop_zero     = (o_out.turn_power == '0) && (o_out.forward_power == '0);

    `ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, start_fire, (r_integ == '0) && (r_prev == '0))
    `ASSERT_SAME(a_gyro_bound, i_clk, i_rst_n, gyro_done, gyro_in_range)
    `ASSERT_SAME(a_lanes_in_step, i_clk, i_rst_n, r_state == ST_MUL2, lanes_level)
    `ASSERT_SAME(a_stop_is_zero, i_clk, i_rst_n, stop_shown, stop_zero)

endmodule

// ----- sim/phh_checker.sv -----
// Checker that predicts the regulator's commands from the words it takes and compares results.
`timescale 1ns / 100ps

module phh_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    phh_in_if                              i_in,
    phh_out_if                             i_out,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [phh_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [phh_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_fault_count,
    output int                             o_owed
);
    import phh_pkg::*;

    typedef logic signed [95:0] t_wide;

    typedef struct packed {
        logic signed [TURN_W-1:0]  turn;
        logic signed [POWER_W-1:0] forward;
        logic                      stop;
    } t_command;

    localparam t_wide FULL_TURN = 360;
    localparam t_wide HALF_TURN = 180;

    logic                       gyro_mode;
    logic signed [GAIN_W-1:0]   kp;
    logic signed [GAIN_W-1:0]   ki;
    logic signed [GAIN_W-1:0]   kd;
    logic [PERIOD_W-1:0]        dt;
    logic [PERIOD_W-1:0]        rate;
    logic signed [POWER_W-1:0]  cruise;
    logic signed [INTEG_W-1:0]  integ;
    logic signed [ERR_W-1:0]    last_err;
    t_command                   owed_commands[$];
    int                         faults;

    function automatic t_wide clamp(t_wide v, int unsigned w);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (w - 1)) - 1;
        lo = -(t_wide'(1) <<< (w - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_wide heading_error(logic gyro, logic signed [ANGLE_W-1:0] angle,
                                            logic signed [DIST_W-1:0] left,
                                            logic signed [DIST_W-1:0] right);
        t_wide deg;
        t_wide l;
        t_wide r;
        if (gyro) begin
            deg = (t_wide'(angle) / 256) % FULL_TURN;
            if (deg > HALF_TURN) begin
                deg = deg - FULL_TURN;
            end
            return (-deg * 65536) / HALF_TURN;
        end
        l = t_wide'(left);
        r = t_wide'(right);
        if (l < 0) l = -l;
        if (r < 0) r = -r;
        return clamp(r - l, ERR_W);
    endfunction

    always @(posedge i_clk) begin : watch
        t_command got;
        t_command want;
        t_wide    err;
        t_wide    step;
        t_wide    deriv;
        t_wide    acc;
        if (!i_rst_n) begin
            gyro_mode = 1'b1;
            kp        = '0;
            ki        = '0;
            kd        = '0;
            dt        = RST_SAMPLE_PERIOD;
            rate      = RST_INVERSE_PERIOD;
            cruise    = '0;
            integ     = '0;
            last_err  = '0;
            owed_commands.delete();
            faults    = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_USE_GYRO:       gyro_mode = i_pwdata[0];
                    REG_GAIN_P:         kp = i_pwdata[GAIN_W-1:0];
                    REG_GAIN_I:         ki = i_pwdata[GAIN_W-1:0];
                    REG_GAIN_D:         kd = i_pwdata[GAIN_W-1:0];
                    REG_SAMPLE_PERIOD:  dt = i_pwdata[PERIOD_W-1:0];
                    REG_INVERSE_PERIOD: rate = i_pwdata[PERIOD_W-1:0];
                    REG_DRIVE_POWER:    cruise = i_pwdata[POWER_W-1:0];
                    default: ;
                endcase
            end

            if (i_out.valid && i_out.ready) begin
                got.turn    = i_out.turn_power;
                got.forward = i_out.forward_power;
                got.stop    = i_out.stop_flag;
                if (owed_commands.size() == 0) begin
                    faults++;
                    $display("%0t: result with none owed: turn %0d forward %0d stop %0b",
                             $time, got.turn, got.forward, got.stop);
                end else begin
                    want = owed_commands.pop_front();
                    if (got.turn !== want.turn) begin
                        faults++;
                        $display("%0t: turn_power expected %0d got %0d",
                                 $time, want.turn, got.turn);
                    end
                    if (got.forward !== want.forward) begin
                        faults++;
                        $display("%0t: forward_power expected %0d got %0d",
                                 $time, want.forward, got.forward);
                    end
                    if (got.stop !== want.stop) begin
                        faults++;
                        $display("%0t: stop_flag expected %0b got %0b",
                                 $time, want.stop, got.stop);
                    end
                end
            end

            if (i_in.valid && i_in.ready) begin
                case (i_in.opcode)
                    OP_START: begin
                        integ    = '0;
                        last_err = '0;
                    end
                    OP_SAMPLE: begin
                        err   = heading_error(gyro_mode, i_in.gyro_angle,
                                              i_in.left_distance, i_in.right_distance);
                        step  = (err * t_wide'(dt)) >>> FRAC_W;
                        deriv = (err - t_wide'(last_err)) * t_wide'(rate);
                        acc   = clamp(t_wide'(integ) + step, INTEG_W);
                        integ = acc[INTEG_W-1:0];
                        acc   = t_wide'(kp) * err + t_wide'(ki) * t_wide'(integ)
                              + t_wide'(kd) * deriv;
                        acc   = clamp(acc >>> FRAC_W, TURN_W);
                        last_err     = err[ERR_W-1:0];
                        want.turn    = acc[TURN_W-1:0];
                        want.forward = cruise;
                        want.stop    = 1'b0;
                        owed_commands.push_back(want);
                    end
                    OP_STOP: begin
                        want.turn    = '0;
                        want.forward = '0;
                        want.stop    = 1'b1;
                        owed_commands.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_owed        <= owed_commands.size();
        o_fault_count <= faults;
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives words and register writes into the heading hold regulator.
`timescale 1ns / 100ps

module tb;
    import phh_pkg::*;

    localparam t_opcode             OP_UNUSED     = 2'd3;
    localparam t_reg_idx            REG_SPARE     = 3'd7;
    localparam logic [GAIN_W-1:0]   GAIN_TOP      = 24'h7FFFFF;
    localparam logic [GAIN_W-1:0]   GAIN_BOTTOM   = 24'h800000;
    localparam logic [POWER_W-1:0]  POWER_TOP     = 16'h7FFF;
    localparam logic [POWER_W-1:0]  POWER_BOTTOM  = 16'h8000;
    localparam int                  SETTLE_CYCLES = 100;
    localparam int                  DRAIN_LIMIT   = 20000;
    localparam int                  PHASES        = 8;
    localparam int                  RANDOM_WORDS  = 850;
    localparam int                  HOLD_CYCLES   = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fault_count;
    int                    owed_count;
    bit                    steady;
    bit                    squeeze;

    phh_in_if  in_bus ();
    phh_out_if out_bus ();

    pid_heading_hold_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    phh_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_bus),
        .i_out         (out_bus),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fault_count (fault_count),
        .o_owed        (owed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("pid_heading_hold_top: mismatch");
        $finish;
    end

    // The long hold lets the output register fill so that the block stalls its input.
    initial begin : receiver
        out_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze) begin
                squeeze = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_bus.ready <= steady || ($urandom_range(99) >= 11);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value, int unsigned w);
        logic [APB_DATA_W-1:0] junk;
        junk    = $urandom_range(1) ? ($urandom << w) : '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= junk | (value & ((32'd1 << w) - 32'd1));
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic apply_setup(logic gyro, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                               logic [GAIN_W-1:0] kd, logic [PERIOD_W-1:0] dt,
                               logic [PERIOD_W-1:0] rate, logic [POWER_W-1:0] cruise);
        write_reg(REG_USE_GYRO, gyro, 1);
        write_reg(REG_GAIN_P, kp, GAIN_W);
        write_reg(REG_GAIN_I, ki, GAIN_W);
        write_reg(REG_GAIN_D, kd, GAIN_W);
        write_reg(REG_SAMPLE_PERIOD, dt, PERIOD_W);
        write_reg(REG_INVERSE_PERIOD, rate, PERIOD_W);
        write_reg(REG_DRIVE_POWER, cruise, POWER_W);
        write_reg(REG_SPARE, $urandom, 0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic offer(t_opcode op, logic [ANGLE_W-1:0] angle,
                         logic [DIST_W-1:0] left, logic [DIST_W-1:0] right);
        int gap;
        if (!steady && $urandom_range(99) < 11) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(100, 1) : $urandom_range(3, 1);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.opcode         <= op;
        in_bus.gyro_angle     <= angle;
        in_bus.left_distance  <= left;
        in_bus.right_distance <= right;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    function automatic logic [GAIN_W-1:0] any_gain();
        if ($urandom_range(1)) return GAIN_W'($urandom);
        return GAIN_W'(int'($urandom_range(262144)) - 131072);
    endfunction

    task automatic offer_random(output bit live);
        int                  pick;
        t_opcode             op;
        logic [ANGLE_W-1:0]  angle;
        logic [DIST_W-1:0]   left;
        logic [DIST_W-1:0]   right;
        pick = $urandom_range(99);
        if (pick < 75) op = OP_SAMPLE;
        else if (pick < 85) op = OP_STOP;
        else if (pick < 93) op = OP_START;
        else op = OP_UNUSED;
        if ($urandom_range(1)) angle = ANGLE_W'($urandom);
        else angle = ANGLE_W'(int'($urandom_range(204800)) - 102400);
        left = $urandom;
        case ($urandom_range(2))
            0:       right = $urandom;
            1:       right = left + DIST_W'(int'($urandom_range(131072)) - 65536);
            default: right = -left + DIST_W'(int'($urandom_range(131072)) - 65536);
        endcase
        offer(op, angle, left, right);
        live = (op != OP_UNUSED);
    endtask

    initial begin : stimulus
        int counted;
        int waited;
        bit live;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_bus.valid          = 1'b0;
        in_bus.opcode         = OP_START;
        in_bus.gyro_angle     = '0;
        in_bus.left_distance  = '0;
        in_bus.right_distance = '0;
        steady                = 1'b0;
        squeeze               = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setup(1'b1, 24'd65536, 24'd32768, 24'd16384,
                    RST_SAMPLE_PERIOD, RST_INVERSE_PERIOD, 16'h4000);
        offer(OP_START, ANGLE_W'($urandom), $urandom, $urandom);
        offer(OP_SAMPLE, '0, $urandom, $urandom);
        offer(OP_SAMPLE, ANGLE_W'(180 * 256), $urandom, $urandom);
        offer(OP_SAMPLE, ANGLE_W'(181 * 256), $urandom, $urandom);
        offer(OP_SAMPLE, ANGLE_W'(-181 * 256), $urandom, $urandom);
        offer(OP_SAMPLE, 24'h7FFFFF, $urandom, $urandom);
        offer(OP_SAMPLE, 24'h800000, $urandom, $urandom);
        offer(OP_SAMPLE, ANGLE_W'(-255), $urandom, $urandom);
        offer(OP_SAMPLE, ANGLE_W'(360 * 256 + 128), $urandom, $urandom);
        offer(OP_STOP, ANGLE_W'($urandom), $urandom, $urandom);
        offer(OP_UNUSED, ANGLE_W'($urandom), $urandom, $urandom);
        offer(OP_START, ANGLE_W'($urandom), $urandom, $urandom);

        settle();
        apply_setup(1'b0, 24'd131072, GAIN_W'(-1000), 24'd300, 16'hFFFF, 16'd1, 16'h8000);
        offer(OP_SAMPLE, ANGLE_W'($urandom), 32'h00000000, 32'h80000000);
        offer(OP_SAMPLE, ANGLE_W'($urandom), 32'h80000000, 32'h00000000);
        offer(OP_SAMPLE, ANGLE_W'($urandom), 32'h80000000, 32'h80000000);
        offer(OP_SAMPLE, ANGLE_W'($urandom), 32'h80000000, 32'h7FFFFFFF);
        offer(OP_SAMPLE, ANGLE_W'($urandom), 32'hFFFFFFFF, 32'h00000001);
        offer(OP_SAMPLE, ANGLE_W'($urandom), 32'h00010000, DIST_W'(-3 * 65536));
        offer(OP_STOP, ANGLE_W'($urandom), $urandom, $urandom);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: apply_setup(1'b1, GAIN_TOP, GAIN_TOP, GAIN_TOP, '1, '1, POWER_TOP);
                1: apply_setup(1'b0, GAIN_BOTTOM, GAIN_BOTTOM, GAIN_BOTTOM, '0, '0,
                               POWER_BOTTOM);
                2: apply_setup(1'b0, GAIN_TOP, GAIN_TOP, GAIN_TOP, '1, '1, POWER_TOP);
                3: apply_setup(1'b1, GAIN_BOTTOM, GAIN_BOTTOM, GAIN_BOTTOM, '0, '0,
                               POWER_BOTTOM);
                default: apply_setup(1'($urandom), any_gain(), any_gain(), any_gain(),
                                     PERIOD_W'($urandom),
                                     $urandom_range(1) ? PERIOD_W'($urandom)
                                                       : PERIOD_W'($urandom_range(100)),
                                     POWER_W'($urandom));
            endcase
            if (ph == 2) squeeze = 1'b1;
            steady  = (ph == 5);
            counted = 0;
            while (counted < RANDOM_WORDS / PHASES) begin
                offer_random(live);
                if (live) counted++;
            end
        end

        in_bus.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (owed_count != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && owed_count == 0) begin
            $display("pid_heading_hold_top: match");
        end else begin
            $display("pid_heading_hold_top: mismatch");
        end
        $finish;
    end

endmodule
